// ----- hw/rtl/sduv_pkg.sv -----
// shared types, constants and helper functions for the sphere direction to uv pipeline
`timescale 1ns / 1ps

package sduv_pkg;

  localparam int          CW             = 36;
  localparam int          CORDIC_STEPS   = 28;
  localparam int          SQRT_STAGES    = 16;
  localparam int          PRESCALE_SHIFT = 16;
  localparam int          MAG_LIMIT      = 32768;
  localparam logic [31:0] HALF_TURN      = 32'h8000_0000;
  localparam logic [31:0] BACK_QUARTER   = 32'hC000_0000;
  localparam logic [15:0] THR_RESET      = 16'd66;

  // square root pipeline payload
  typedef struct packed {
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic signed [16:0] cz;
    logic               zero;
    logic               pole;
    logic [31:0]        root;
    logic [34:0]        rem;
    logic [31:0]        rad;
  } sduv_sq_t;

  // cordic pipeline payload, polar and azimuth rotations side by side
  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic [31:0]          pang;
    logic [31:0]          aang;
    logic                 zero;
    logic                 pole;
  } sduv_cor_t;

  // arctan(2^-i) in turns, Q0.32
  function automatic logic [31:0] atan_turns(input int idx);
    case (idx)
      0:       return 32'd536870912;
      1:       return 32'd316933406;
      2:       return 32'd167458907;
      3:       return 32'd85004756;
      4:       return 32'd42667331;
      5:       return 32'd21354465;
      6:       return 32'd10679838;
      7:       return 32'd5340245;
      8:       return 32'd2670163;
      9:       return 32'd1335087;
      10:      return 32'd667544;
      11:      return 32'd333772;
      12:      return 32'd166886;
      13:      return 32'd83443;
      14:      return 32'd41722;
      15:      return 32'd20861;
      16:      return 32'd10430;
      17:      return 32'd5215;
      18:      return 32'd2608;
      19:      return 32'd1304;
      20:      return 32'd652;
      21:      return 32'd326;
      22:      return 32'd163;
      23:      return 32'd81;
      24:      return 32'd41;
      25:      return 32'd20;
      26:      return 32'd10;
      27:      return 32'd5;
      default: return 32'd0;
    endcase
  endfunction

  // shift right that truncates the magnitude and keeps the sign
  function automatic logic signed [CW-1:0] shr_mag(input logic signed [CW-1:0] v, input int n);
    logic signed [CW-1:0] q;
    logic [CW-1:0]        mask;
    mask = (CW'(1) << n) - CW'(1);
    q    = v >>> n;
    if (v[CW-1] && ((v & mask) != '0)) begin
      q = q + CW'(1);
    end
    return q;
  endfunction

  // one digit of the restoring square root
  function automatic sduv_sq_t sqrt_step(input sduv_sq_t s);
    sduv_sq_t   r;
    logic [34:0] rem_n;
    logic [34:0] trial;
    r     = s;
    rem_n = {s.rem[32:0], s.rad[31:30]};
    trial = {1'b0, s.root, 2'b01};
    if (rem_n >= trial) begin
      r.rem  = rem_n - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem_n;
      r.root = {s.root[30:0], 1'b0};
    end
    r.rad = {s.rad[29:0], 2'b00};
    return r;
  endfunction

endpackage

// ----- hw/rtl/sphere_direction_to_uv.sv -----
// top level: direction vector to spherical texture coordinates
`timescale 1ns / 1ps
//
//  channel  direction  handshake                 beat contents
//  in       input      in_valid_i / in_stall_o   dir_x_i, dir_y_i, dir_z_i
//  out      output     out_valid_o / out_stall_i tex_u_o, tex_v_o, at_pole_o, zero_input_o
//  cfg      input      psel/penable/pwrite       pole_threshold at address 0
//
//  one beat per cycle while no result waits in the skid register; the path from
//  accept to result runs through 7 front stages, 16 square root stages of two
//  bits each, one cordic setup stage, 28 cordic steps and the output register
//  reset clears all valid bits and loads pole_threshold with 66
//  a result refused under out_stall_i moves into a skid register; while it
//  waits there the whole pipeline holds and in_stall_o (a register output) is
//  high, so the input stalls only in that case; bubbles flow through otherwise
//
module sphere_direction_to_uv #(
  parameter int COMPONENT_BITS   = 16,
  parameter int UV_FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input beats
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [COMPONENT_BITS-1:0]   dir_x_i,
  input  logic [COMPONENT_BITS-1:0]   dir_y_i,
  input  logic [COMPONENT_BITS-1:0]   dir_z_i,
  // output beats
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [UV_FRACTION_BITS-1:0] tex_u_o,
  output logic [UV_FRACTION_BITS:0]   tex_v_o,
  output logic                        at_pole_o,
  output logic                        zero_input_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int F = UV_FRACTION_BITS;
  localparam int CW = sduv_pkg::CW;

  // global advance: everything moves unless a result waits in the skid register
  logic en;

  // config register and its square, kept for the pole product
  logic [15:0] thr_q;
  logic [31:0] thr_sq_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & ~paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {16'd0, thr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= sduv_pkg::THR_RESET;
      thr_sq_q <= 32'(sduv_pkg::THR_RESET) * 32'(sduv_pkg::THR_RESET);
    end else begin
      if (cfg_wr) begin
        thr_q <= pwdata[15:0];
      end
      thr_sq_q <= thr_q * thr_q;
    end
  end

  // front: prescale, squares and pole test
  logic               sq_valid [sduv_pkg::SQRT_STAGES+1];
  sduv_pkg::sduv_sq_t sq_data  [sduv_pkg::SQRT_STAGES+1];

  sduv_front #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .thr_sq_i(thr_sq_q),
    .valid_o (sq_valid[0]),
    .data_o  (sq_data[0])
  );

  // sqrt(rho2 << 32), the polar sine scaled like the cordic inputs
  for (genvar g = 0; g < sduv_pkg::SQRT_STAGES; g++) begin : g_sqrt
    sduv_sqrt_stage u_sqrt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sq_valid[g]),
      .data_i (sq_data[g]),
      .valid_o(sq_valid[g+1]),
      .data_o (sq_data[g+1])
    );
  end

  // cordic setup: fold the left half plane onto the right
  logic                cor_valid [sduv_pkg::CORDIC_STEPS+1];
  sduv_pkg::sduv_cor_t cor_data  [sduv_pkg::CORDIC_STEPS+1];
  logic                pre_valid_q;
  sduv_pkg::sduv_cor_t pre_data_q, pre_data_d;
  logic signed [CW-1:0] px0, py0, ax0, ay0;
  sduv_pkg::sduv_sq_t   sq_last;

  assign sq_last = sq_data[sduv_pkg::SQRT_STAGES];

  always_comb begin
    px0 = CW'(sq_last.cz) <<< sduv_pkg::PRESCALE_SHIFT;
    py0 = $signed({{(CW-32){1'b0}}, sq_last.root});
    ax0 = CW'(sq_last.cx) <<< sduv_pkg::PRESCALE_SHIFT;
    ay0 = CW'(sq_last.cy) <<< sduv_pkg::PRESCALE_SHIFT;
    pre_data_d      = '0;
    pre_data_d.zero = sq_last.zero;
    pre_data_d.pole = sq_last.pole;
    if (px0[CW-1]) begin
      pre_data_d.px   = -px0;
      pre_data_d.py   = -py0;
      pre_data_d.pang = sduv_pkg::HALF_TURN;
    end else begin
      pre_data_d.px   = px0;
      pre_data_d.py   = py0;
      pre_data_d.pang = '0;
    end
    if (ax0[CW-1]) begin
      pre_data_d.ax   = -ax0;
      pre_data_d.ay   = -ay0;
      pre_data_d.aang = sduv_pkg::HALF_TURN;
    end else begin
      pre_data_d.ax   = ax0;
      pre_data_d.ay   = ay0;
      pre_data_d.aang = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else if (en) begin
      pre_valid_q <= sq_valid[sduv_pkg::SQRT_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_data_q <= pre_data_d;
    end
  end

  assign cor_valid[0] = pre_valid_q;
  assign cor_data[0]  = pre_data_q;

  for (genvar g = 0; g < sduv_pkg::CORDIC_STEPS; g++) begin : g_cordic
    sduv_cordic_stage #(
      .STEP(g)
    ) u_cordic (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(cor_valid[g]),
      .data_i (cor_data[g]),
      .valid_o(cor_valid[g+1]),
      .data_o (cor_data[g+1])
    );
  end

  // output stage: clamp polar angle, round both angles to F bits
  sduv_pkg::sduv_cor_t cor_last;
  logic [31:0]         pa;
  logic [33:0]         v_sum;
  logic [F:0]          v_q;
  logic [32:0]         u_sum;
  logic                out_valid_q;
  logic [F-1:0]        tex_u_q, tex_u_d;
  logic [F:0]          tex_v_q, tex_v_d;
  logic                pole_q, pole_d;
  logic                zero_q;
  // skid register for a result refused at the output
  logic                sk_valid_q;
  logic [F-1:0]        sk_u_q;
  logic [F:0]          sk_v_q;
  logic                sk_pole_q;
  logic                sk_zero_q;

  assign cor_last = cor_data[sduv_pkg::CORDIC_STEPS];

  always_comb begin
    if (cor_last.pang >= sduv_pkg::BACK_QUARTER) begin
      pa = '0;
    end else if (cor_last.pang > sduv_pkg::HALF_TURN) begin
      pa = sduv_pkg::HALF_TURN;
    end else begin
      pa = cor_last.pang;
    end
    v_sum   = {1'b0, pa, 1'b0} + (34'd1 << (31 - F));
    v_q     = (F+1)'(v_sum >> (32 - F));
    u_sum   = {1'b0, cor_last.aang} + (33'd1 << (31 - F));
    pole_d  = cor_last.pole & ~cor_last.zero;
    tex_v_d = cor_last.zero ? '0 : ((F+1)'(1) << F) - v_q;
    tex_u_d = (cor_last.zero | cor_last.pole) ? '0 : F'(u_sum >> (32 - F));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cor_valid[sduv_pkg::CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tex_u_q <= tex_u_d;
      tex_v_q <= tex_v_d;
      pole_q  <= pole_d;
      zero_q  <= cor_last.zero;
    end
  end

  // skid fills when the output register beat is refused, empties when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_valid_q <= 1'b0;
    end else if (sk_valid_q) begin
      if (!out_stall_i) begin
        sk_valid_q <= 1'b0;
      end
    end else if (out_valid_q && out_stall_i) begin
      sk_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!sk_valid_q) begin
      sk_u_q    <= tex_u_q;
      sk_v_q    <= tex_v_q;
      sk_pole_q <= pole_q;
      sk_zero_q <= zero_q;
    end
  end

  assign in_stall_o   = sk_valid_q;
  assign en           = ~sk_valid_q;
  assign out_valid_o  = sk_valid_q | out_valid_q;
  assign tex_u_o      = sk_valid_q ? sk_u_q : tex_u_q;
  assign tex_v_o      = sk_valid_q ? sk_v_q : tex_v_q;
  assign at_pole_o    = sk_valid_q ? sk_pole_q : pole_q;
  assign zero_input_o = sk_valid_q ? sk_zero_q : zero_q;

`ifndef NO_ASSERTIONS
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_input_o |-> tex_u_o == '0 && tex_v_o == '0 && !at_pole_o)
    else $error("zero input beat carries nonzero result");

  a_pole_u: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_pole_o |-> tex_u_o == '0)
    else $error("pole beat with nonzero azimuth");

  a_v_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tex_v_o <= ((F+1)'(1) << F))
    else $error("tex_v above one");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a waiting result");
`endif

endmodule

// ----- hw/rtl/sduv_front.sv -----
// front stages: prescale, squares, radius sums and pole test
`timescale 1ns / 1ps

module sduv_front #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [COMPONENT_BITS-1:0] dir_x_i,
  input  logic [COMPONENT_BITS-1:0] dir_y_i,
  input  logic [COMPONENT_BITS-1:0] dir_z_i,
  input  logic [31:0]               thr_sq_i,
  output logic                      valid_o,
  output sduv_pkg::sduv_sq_t        data_o
);

  localparam int CB = COMPONENT_BITS;
  localparam int MW = (CB > 16) ? CB : 16;
  localparam int KW = $clog2(MW);

  // stage a: raw inputs
  logic                 a_valid_q;
  logic [2:0][CB-1:0]   a_c_q;
  // stage b: magnitudes
  logic                 b_valid_q;
  logic [2:0][MW-1:0]   b_mag_q, b_mag_d;
  logic [2:0]           b_neg_q, b_neg_d;
  logic [MW-1:0]        b_m_q, b_m_d;
  // stage c: scaled magnitudes
  logic                 c_valid_q;
  logic [2:0][15:0]     c_s_q, c_s_d;
  logic [2:0]           c_neg_q;
  logic                 c_zero_q, c_zero_d;
  logic [KW-1:0]        ksel;
  // stage d: squares
  logic                 d_valid_q;
  logic [2:0][31:0]     d_sq_q, d_sq_d;
  logic [2:0][16:0]     d_cs_q, d_cs_d;
  logic                 d_zero_q;
  // stage e: sums
  logic                 e_valid_q;
  logic [31:0]          e_rho2_q, e_rho2_d;
  logic [31:0]          e_r2_q, e_r2_d;
  logic [2:0][16:0]     e_cs_q;
  logic                 e_zero_q;
  // stage f: threshold product
  logic                 f_valid_q;
  logic [63:0]          f_prod_q, f_prod_d;
  logic [31:0]          f_rho2_q;
  logic [2:0][16:0]     f_cs_q;
  logic                 f_zero_q;
  // stage g: pole decision
  logic                 g_valid_q;
  sduv_pkg::sduv_sq_t   g_data_q, g_data_d;

  always_comb begin
    b_m_d = '0;
    for (int i = 0; i < 3; i++) begin
      b_neg_d[i] = a_c_q[i][CB-1];
      b_mag_d[i] = MW'(a_c_q[i][CB-1] ? (~a_c_q[i] + 1'b1) : a_c_q[i]);
      if (b_mag_d[i] > b_m_d) begin
        b_m_d = b_mag_d[i];
      end
    end
  end

  // smallest shift that brings the largest magnitude into range
  always_comb begin
    ksel = '0;
    for (int k = MW - 1; k >= 0; k--) begin
      if ((b_m_q >> k) <= MW'(sduv_pkg::MAG_LIMIT)) begin
        ksel = KW'(k);
      end
    end
    for (int i = 0; i < 3; i++) begin
      c_s_d[i] = 16'(b_mag_q[i] >> ksel);
    end
    c_zero_d = (b_m_q == '0);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_cs_d[i] = c_neg_q[i] ? (17'd0 - {1'b0, c_s_q[i]}) : {1'b0, c_s_q[i]};
      d_sq_d[i] = c_s_q[i] * c_s_q[i];
    end
  end

  always_comb begin
    e_rho2_d = d_sq_q[0] + d_sq_q[1];
    e_r2_d   = e_rho2_d + d_sq_q[2];
  end

  always_comb begin
    f_prod_d = thr_sq_i * e_r2_q;
  end

  always_comb begin
    g_data_d      = '0;
    g_data_d.cx   = f_cs_q[0];
    g_data_d.cy   = f_cs_q[1];
    g_data_d.cz   = f_cs_q[2];
    g_data_d.zero = f_zero_q;
    g_data_d.pole = (f_rho2_q == '0) || ({f_rho2_q, 32'd0} < f_prod_q);
    g_data_d.rad  = f_rho2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
      g_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_c_q    <= {dir_z_i, dir_y_i, dir_x_i};
      b_mag_q  <= b_mag_d;
      b_neg_q  <= b_neg_d;
      b_m_q    <= b_m_d;
      c_s_q    <= c_s_d;
      c_neg_q  <= b_neg_q;
      c_zero_q <= c_zero_d;
      d_sq_q   <= d_sq_d;
      d_cs_q   <= d_cs_d;
      d_zero_q <= c_zero_q;
      e_rho2_q <= e_rho2_d;
      e_r2_q   <= e_r2_d;
      e_cs_q   <= d_cs_q;
      e_zero_q <= d_zero_q;
      f_prod_q <= f_prod_d;
      f_rho2_q <= e_rho2_q;
      f_cs_q   <= e_cs_q;
      f_zero_q <= e_zero_q;
      g_data_q <= g_data_d;
    end
  end

  assign valid_o = g_valid_q;
  assign data_o  = g_data_q;

endmodule

// ----- hw/rtl/sduv_sqrt_stage.sv -----
// square root pipeline stage, two result bits per stage
`timescale 1ns / 1ps

module sduv_sqrt_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  sduv_pkg::sduv_sq_t data_i,
  output logic               valid_o,
  output sduv_pkg::sduv_sq_t data_o
);

  logic               valid_q;
  sduv_pkg::sduv_sq_t data_q, data_d;

  assign data_d = sduv_pkg::sqrt_step(sduv_pkg::sqrt_step(data_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/sduv_cordic_stage.sv -----
// one vectoring cordic step for the polar and azimuth angles
`timescale 1ns / 1ps

module sduv_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  sduv_pkg::sduv_cor_t data_i,
  output logic                valid_o,
  output sduv_pkg::sduv_cor_t data_o
);

  localparam logic [31:0] ATAN = sduv_pkg::atan_turns(STEP);

  logic                          valid_q;
  sduv_pkg::sduv_cor_t           data_q, data_d;
  logic signed [sduv_pkg::CW-1:0] pdx, pdy, adx, ady;

  always_comb begin
    data_d = data_i;
    pdx    = sduv_pkg::shr_mag(data_i.py, STEP);
    pdy    = sduv_pkg::shr_mag(data_i.px, STEP);
    adx    = sduv_pkg::shr_mag(data_i.ay, STEP);
    ady    = sduv_pkg::shr_mag(data_i.ax, STEP);
    if (!data_i.py[sduv_pkg::CW-1]) begin
      data_d.px   = data_i.px + pdx;
      data_d.py   = data_i.py - pdy;
      data_d.pang = data_i.pang + ATAN;
    end else begin
      data_d.px   = data_i.px - pdx;
      data_d.py   = data_i.py + pdy;
      data_d.pang = data_i.pang - ATAN;
    end
    if (!data_i.ay[sduv_pkg::CW-1]) begin
      data_d.ax   = data_i.ax + adx;
      data_d.ay   = data_i.ay - ady;
      data_d.aang = data_i.aang + ATAN;
    end else begin
      data_d.ax   = data_i.ax - adx;
      data_d.ay   = data_i.ay + ady;
      data_d.aang = data_i.aang - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
